// ===== design/u16u8_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package u16u8_pkg;

  // One input item: a UTF-16 code unit and the end-of-stream flag
  typedef struct packed {
    logic [15:0] code_unit;
    logic        end_of_input;
  } in_item_t;

  // One result item: a single byte of output
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       error;
  } out_item_t;

  // Work for the back end: optional BOM, then cnt bytes from the bytes list.
  // With err set, cnt is 1 and the single byte is the error result.
  typedef struct packed {
    logic            bom;
    logic [2:0]      cnt;
    logic [3:0][7:0] bytes;
    logic            err;
  } job_t;

  localparam logic [2:0] BOM_LEN = 3'd3;
  localparam logic [7:0] BOM_B0  = 8'hEF;
  localparam logic [7:0] BOM_B1  = 8'hBB;
  localparam logic [7:0] BOM_B2  = 8'hBF;

  // Surrogate ranges by the top six bits of a code unit
  localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
  localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

  localparam logic [20:0] SUPP_BASE = 21'h10000;

endpackage

`default_nettype wire

// ===== design/u16u8_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module u16u8_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic                 cfg_wr_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire u16u8_pkg::in_item_t  in_data,
  output logic                      push_valid,
  input  wire logic                 push_ready,
  output u16u8_pkg::job_t           push_job
);
  import u16u8_pkg::*;

  typedef enum logic [1:0] {
    UC_PLAIN,
    UC_HIGH,
    UC_LOW
  } unit_class_t;

  logic        emit_bom_r;
  logic        bom_sent_r;
  logic        halted_r;
  logic        pending_valid_r, pending_valid_nxt;
  logic [9:0]  pending_payload_r, pending_payload_nxt;

  unit_class_t ucls;
  logic        fail;
  logic [20:0] supp_cp;
  job_t        job;
  logic        accept;

  // UTF-8 bytes of a code point in the basic plane
  function automatic job_t encode_bmp(input logic [15:0] cp);
    job_t j;
    j = '0;
    if (cp[15:7] == 9'd0) begin
      j.cnt      = 3'd1;
      j.bytes[0] = {1'b0, cp[6:0]};
    end else if (cp[15:11] == 5'd0) begin
      j.cnt      = 3'd2;
      j.bytes[0] = {3'b110, cp[10:6]};
      j.bytes[1] = {2'b10, cp[5:0]};
    end else begin
      j.cnt      = 3'd3;
      j.bytes[0] = {4'b1110, cp[15:12]};
      j.bytes[1] = {2'b10, cp[11:6]};
      j.bytes[2] = {2'b10, cp[5:0]};
    end
    return j;
  endfunction

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  // Classify the incoming unit
  always_comb begin
    unique case (in_data.code_unit[15:10])
      HIGH_SURR_TAG: ucls = UC_HIGH;
      LOW_SURR_TAG:  ucls = UC_LOW;
      default:       ucls = UC_PLAIN;
    endcase
  end

  assign supp_cp = {1'b0, pending_payload_r, in_data.code_unit[9:0]} + SUPP_BASE;

  // Build the job and the next surrogate state
  always_comb begin
    job                 = '0;
    fail                = 1'b0;
    pending_valid_nxt   = pending_valid_r;
    pending_payload_nxt = pending_payload_r;
    if (pending_valid_r) begin
      pending_valid_nxt   = 1'b0;
      pending_payload_nxt = '0;
      if (ucls == UC_LOW) begin
        job.cnt      = 3'd4;
        job.bytes[0] = {5'b11110, supp_cp[20:18]};
        job.bytes[1] = {2'b10, supp_cp[17:12]};
        job.bytes[2] = {2'b10, supp_cp[11:6]};
        job.bytes[3] = {2'b10, supp_cp[5:0]};
      end else begin
        fail = 1'b1;
      end
    end else begin
      unique case (ucls)
        UC_HIGH: begin
          if (in_data.end_of_input) begin
            fail = 1'b1;
          end else begin
            pending_valid_nxt   = 1'b1;
            pending_payload_nxt = in_data.code_unit[9:0];
          end
        end
        UC_LOW:  fail = 1'b1;
        default: job = encode_bmp(in_data.code_unit);
      endcase
    end
    // error result replaces any payload bytes
    if (fail) begin
      job.cnt   = 3'd1;
      job.bytes = '0;
      job.err   = 1'b1;
    end
    job.bom = !bom_sent_r && emit_bom_r;
  end

  assign push_job   = job;
  assign push_valid = in_valid && !halted_r && (job.bom || (job.cnt != 3'd0));

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_bom_r <= 1'b1;
    end else if (cfg_wr_en) begin
      emit_bom_r <= cfg_wr_data;
    end
  end

  // Stream state, updated on each transfer while running
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bom_sent_r        <= 1'b0;
      halted_r          <= 1'b0;
      pending_valid_r   <= 1'b0;
      pending_payload_r <= '0;
    end else if (accept && !halted_r) begin
      bom_sent_r        <= 1'b1;
      halted_r          <= fail;
      pending_valid_r   <= pending_valid_nxt;
      pending_payload_r <= pending_payload_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/u16u8_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module u16u8_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire u16u8_pkg::job_t  push_job,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output u16u8_pkg::job_t       pop_job
);
  import u16u8_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/u16u8_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module u16u8_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             job_valid,
  output logic                  job_ready,
  input  wire u16u8_pkg::job_t  job,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output u16u8_pkg::out_item_t  out_data
);
  import u16u8_pkg::*;

  logic [2:0] pos_r, pos_nxt;
  logic       out_valid_r;
  out_item_t  out_data_r;
  out_item_t  cur;
  logic [2:0] total;
  logic [2:0] idx;
  logic       load;
  logic       is_last;

  assign total   = (job.bom ? BOM_LEN : 3'd0) + job.cnt;
  assign idx     = pos_r - (job.bom ? BOM_LEN : 3'd0);
  assign is_last = (pos_r == total - 3'd1);
  assign load    = job_valid && (!out_valid_r || out_ready);

  // Pick the byte at the current position of the job
  always_comb begin
    cur = '0;
    if (job.bom && (pos_r < BOM_LEN)) begin
      case (pos_r[1:0])
        2'd0:    cur.out_byte = BOM_B0;
        2'd1:    cur.out_byte = BOM_B1;
        default: cur.out_byte = BOM_B2;
      endcase
    end else begin
      cur.out_byte = job.bytes[idx[1:0]];
      cur.error    = job.err;
    end
    cur.last_of_run = is_last;
  end

  assign job_ready = load && is_last;
  assign pos_nxt   = is_last ? 3'd0 : pos_r + 3'd1;

  // Position within the current job
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (load) begin
      pos_r <= pos_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= cur;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== design/utf16be_to_utf8_transcoder.sv =====
// Channel  | Ports                                  | Moves
// ---------+----------------------------------------+--------------------------------
// input    | in_valid, in_ready, in_data            | one UTF-16 code unit + end flag
// result   | out_valid, out_ready, out_data         | one UTF-8 byte + last/error
// config   | cfg_wr_en, cfg_wr_data                 | emit_bom register, no wait
//
// The back end sends one byte per cycle while a job is queued and out_ready is high;
// an item makes 0 to 4 bytes, plus 3 for the BOM on the first item.
// The front classifies an item in the cycle it is taken; the job queue
// (QUEUE_DEPTH entries) lets input keep flowing while the back end is busy.
// Reset is synchronous, active low, and clears all stream state; emit_bom resets to 1.
// A stalled out_ready holds the output register and backs up into the queue.
`timescale 1ns / 1ps
`default_nettype none

module utf16be_to_utf8_transcoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic                 cfg_wr_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire u16u8_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output u16u8_pkg::out_item_t      out_data
);
  import u16u8_pkg::*;

  logic push_valid, push_ready;
  job_t push_job;
  logic pop_valid, pop_ready;
  job_t pop_job;

  u16u8_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_job    (push_job)
  );

  u16u8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  u16u8_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (pop_valid),
    .job_ready (pop_ready),
    .job       (pop_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== design/u16u8_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module u16u8_checker (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 out_valid,
  input  wire logic                 out_ready,
  input  wire u16u8_pkg::out_item_t out_data
);

  // Nothing is offered in the cycle after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // An error result is a zero byte that closes its run
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error |-> out_data.out_byte == 8'h00 && out_data.last_of_run)
    else $error("malformed error result");

  // After an error transfer the block stays silent until reset
  a_err_halt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.error |=> !out_valid)
    else $error("result after error");

endmodule

bind utf16be_to_utf8_transcoder u16u8_checker u_chk (.*);

`default_nettype wire
